FILE: src/mmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants of the memory map coalescer
// Holds the entry record that travels from the front end through the queue
// to the back end, the memory type codes and the queue sizing.
// ----------------------------------------------------------------------------
package mmc_pkg;

  // Field widths
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned PAGES_W = 52;
  localparam int unsigned ATTR_W  = 64;
  localparam int unsigned PAGE_SHIFT = 12;

  // Saturation value of a page count
  localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

  // Attribute bit that marks a runtime region
  localparam int unsigned ATTR_RUNTIME_BIT = 63;

  // Memory type codes
  localparam logic [TYPE_W-1:0] TYPE_RESERVED     = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_LOADER_CODE  = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_LOADER_DATA  = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_BS_CODE      = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_RT_CODE      = 4'd5;
  localparam logic [TYPE_W-1:0] TYPE_RT_DATA      = 4'd6;
  localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_UNUSABLE     = 4'd8;
  localparam logic [TYPE_W-1:0] TYPE_MMIO         = 4'd11;
  localparam logic [TYPE_W-1:0] TYPE_MMIO_PORT    = 4'd12;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_RT_OFFSET  = 1'b0,
    REG_MMIO_START = 1'b1
  } cfg_reg_e;

  // Queue between front and back end
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One closed map entry on its way to the output
  typedef struct packed {
    logic [TYPE_W-1:0]  mem_type;
    logic [ADDR_W-1:0]  phys;
    logic [ADDR_W-1:0]  virt;
    logic [PAGES_W-1:0] pages;
    logic [ATTR_W-1:0]  attr;
    logic               last;
    logic               error;
  } entry_t;

  // Push request from the front end: slot a alone, or slots a and b
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

  // Types that survive reclaim; everything else becomes conventional memory.
  function automatic logic type_kept(logic [TYPE_W-1:0] t);
    return (t == TYPE_RESERVED) || (t == TYPE_LOADER_CODE) ||
           (t == TYPE_LOADER_DATA) || (t == TYPE_RT_CODE) ||
           (t == TYPE_RT_DATA) || (t == TYPE_UNUSABLE) ||
           (t == TYPE_MMIO) || (t == TYPE_MMIO_PORT);
  endfunction

  // Memory mapped IO types get consecutive virtual addresses.
  function automatic logic type_is_mmio(logic [TYPE_W-1:0] t);
    return (t == TYPE_MMIO) || (t == TYPE_MMIO_PORT);
  endfunction

endpackage

FILE: src/memory_map_coalescer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_coalescer: memory map compaction
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_ready_o   one memory descriptor
//   out      output     out_valid_o / out_ready_i one compacted map entry
//   cfg      input      cfg_we_i                  runtime offset, MMIO start
//
// A descriptor is taken every cycle while the queue has two free slots.
// A closed entry passes through the queue and then the output register;
// the output drains one entry per cycle while out_ready_i is high, so a
// map sustains one descriptor per cycle while each closes at most one entry.
// The back end's address adders and output register set the output pace.
// Reset clears the control state; no clearing pass is needed.
// Output stalls fill the four-entry queue; in_ready_o drops once fewer than
// two of its slots are free.
// ----------------------------------------------------------------------------
module memory_map_coalescer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mmc_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mmc_pkg::TYPE_W-1:0]   mem_type_i,
  input  logic [mmc_pkg::ADDR_W-1:0]   phys_start_i,
  input  logic [mmc_pkg::ADDR_W-1:0]   virt_start_i,
  input  logic [mmc_pkg::PAGES_W-1:0]  page_count_i,
  input  logic [mmc_pkg::ATTR_W-1:0]   attr_bits_i,
  input  logic                         in_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mmc_pkg::TYPE_W-1:0]   out_type_o,
  output logic [mmc_pkg::ADDR_W-1:0]   out_phys_start_o,
  output logic [mmc_pkg::ADDR_W-1:0]   out_virt_start_o,
  output logic [mmc_pkg::PAGES_W-1:0]  out_page_count_o,
  output logic [mmc_pkg::ATTR_W-1:0]   out_attr_o,
  output logic                         out_last_o,
  output logic                         out_error_o
);

  mmc_pkg::push_t  push;
  mmc_pkg::entry_t rec_a;
  mmc_pkg::entry_t rec_b;
  mmc_pkg::entry_t q_data;
  logic            q_room;
  logic            q_valid;
  logic            q_pop;

  // Front end: check, reclaim and merge
  mmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mem_type_i   (mem_type_i),
    .phys_start_i (phys_start_i),
    .virt_start_i (virt_start_i),
    .page_count_i (page_count_i),
    .attr_bits_i  (attr_bits_i),
    .in_last_i    (in_last_i),
    .q_room_i     (q_room),
    .push_o       (push),
    .rec_a_o      (rec_a),
    .rec_b_o      (rec_b)
  );

  // Queue of closed entries
  mmc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rec_a_i    (rec_a),
    .rec_b_i    (rec_b),
    .room_o     (q_room),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data),
    .pop_i      (q_pop)
  );

  // Back end: address assignment and output
  mmc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_type_o       (out_type_o),
    .out_phys_start_o (out_phys_start_o),
    .out_virt_start_o (out_virt_start_o),
    .out_page_count_o (out_page_count_o),
    .out_attr_o       (out_attr_o),
    .out_last_o       (out_last_o),
    .out_error_o      (out_error_o)
  );

endmodule

FILE: src/mmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_front: descriptor intake, checking and merging
// Accepts one descriptor per cycle while q_room_i is high, checks the first
// one of a map, reclaims types, merges adjacent descriptors into the pending
// entry and pushes each closed entry (at most two per descriptor) to the queue.
// ----------------------------------------------------------------------------
module mmc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mmc_pkg::TYPE_W-1:0]   mem_type_i,
  input  logic [mmc_pkg::ADDR_W-1:0]   phys_start_i,
  input  logic [mmc_pkg::ADDR_W-1:0]   virt_start_i,
  input  logic [mmc_pkg::PAGES_W-1:0]  page_count_i,
  input  logic [mmc_pkg::ATTR_W-1:0]   attr_bits_i,
  input  logic                         in_last_i,
  input  logic                         q_room_i,
  output mmc_pkg::push_t               push_o,
  output mmc_pkg::entry_t              rec_a_o,
  output mmc_pkg::entry_t              rec_b_o
);

  // Pending entry and map control state
  mmc_pkg::entry_t pend_q, pend_d;
  logic            pend_valid_q, pend_valid_d;
  logic            at_first_q, at_first_d;
  logic            discard_q, discard_d;

  logic                         accept;
  logic                         first_bad;
  logic [mmc_pkg::TYPE_W-1:0]   cls_type;
  logic [mmc_pkg::ADDR_W-1:0]   pend_end;
  logic                         merge;
  logic [mmc_pkg::PAGES_W:0]    page_sum;
  logic [mmc_pkg::PAGES_W-1:0]  page_sat;
  logic                         close_v;
  logic                         fin_v;
  logic                         err_v;
  mmc_pkg::entry_t              close_rec;
  mmc_pkg::entry_t              fin_rec;
  mmc_pkg::entry_t              err_rec;

  // Room for two records is needed, since one descriptor can close two entries.
  assign in_ready_o = q_room_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classification and adjacency against the pending entry
  assign first_bad = (mem_type_i != mmc_pkg::TYPE_BS_CODE) || (phys_start_i != '0) ||
                     (page_count_i != mmc_pkg::PAGES_W'(1));
  assign cls_type  = mmc_pkg::type_kept(mem_type_i) ? mem_type_i
                                                    : mmc_pkg::TYPE_CONVENTIONAL;
  assign pend_end  = pend_q.phys + {pend_q.pages, {mmc_pkg::PAGE_SHIFT{1'b0}}};
  assign merge     = pend_valid_q && (cls_type == pend_q.mem_type) &&
                     (attr_bits_i == pend_q.attr) && (phys_start_i == pend_end);
  assign page_sum  = {1'b0, pend_q.pages} + {1'b0, page_count_i};
  assign page_sat  = page_sum[mmc_pkg::PAGES_W] ? mmc_pkg::PAGES_MAX
                                                : page_sum[mmc_pkg::PAGES_W-1:0];

  // Next state of the pending entry and the records to push
  always_comb begin
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    at_first_d   = at_first_q;
    discard_d    = discard_q;
    close_v      = 1'b0;
    fin_v        = 1'b0;
    err_v        = 1'b0;
    if (accept) begin
      priority if (discard_q) begin
        if (in_last_i) begin
          discard_d  = 1'b0;
          at_first_d = 1'b1;
        end
      end else if (at_first_q) begin
        if (first_bad) begin
          err_v        = 1'b1;
          pend_valid_d = 1'b0;
          discard_d    = !in_last_i;
        end else begin
          pend_d.mem_type = mmc_pkg::TYPE_UNUSABLE;
          pend_d.phys     = '0;
          pend_d.virt     = virt_start_i;
          pend_d.pages    = mmc_pkg::PAGES_W'(1);
          pend_d.attr     = attr_bits_i;
          pend_valid_d    = 1'b1;
          at_first_d      = 1'b0;
          if (in_last_i) begin
            fin_v        = 1'b1;
            pend_valid_d = 1'b0;
            at_first_d   = 1'b1;
          end
        end
      end else begin
        if (merge) begin
          pend_d.pages = page_sat;
        end else begin
          close_v         = pend_valid_q;
          pend_d.mem_type = cls_type;
          pend_d.phys     = phys_start_i;
          pend_d.virt     = virt_start_i;
          pend_d.pages    = page_count_i;
          pend_d.attr     = attr_bits_i;
          pend_valid_d    = 1'b1;
        end
        if (in_last_i) begin
          fin_v        = 1'b1;
          pend_valid_d = 1'b0;
          at_first_d   = 1'b1;
        end
      end
    end
  end

  // Records handed to the queue
  always_comb begin
    close_rec       = pend_q;
    close_rec.last  = 1'b0;
    close_rec.error = 1'b0;
    fin_rec         = pend_d;
    fin_rec.last    = 1'b1;
    fin_rec.error   = 1'b0;
    err_rec         = '0;
    err_rec.last    = 1'b1;
    err_rec.error   = 1'b1;
  end

  assign push_o.push_a = err_v || close_v || fin_v;
  assign push_o.push_b = close_v && fin_v;
  assign rec_a_o = err_v ? err_rec : (close_v ? close_rec : fin_rec);
  assign rec_b_o = fin_rec;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      at_first_q   <= 1'b1;
      discard_q    <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      at_first_q   <= at_first_d;
      discard_q    <= discard_d;
    end
  end

  // Pending entry payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

FILE: src/mmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_queue: short entry queue between front and back end
// Takes up to two records per cycle and gives one per cycle while pop_i is high, in order.
// ----------------------------------------------------------------------------
module mmc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mmc_pkg::push_t  push_i,
  input  mmc_pkg::entry_t rec_a_i,
  input  mmc_pkg::entry_t rec_b_i,
  output logic            room_o,
  output logic            rd_valid_o,
  output mmc_pkg::entry_t rd_data_o,
  input  logic            pop_i
);

  mmc_pkg::entry_t               slot_q [mmc_pkg::QDEPTH];
  logic [mmc_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mmc_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mmc_pkg::QCNT_W-1:0]    count_q, count_d;
  logic [mmc_pkg::QPTR_W-1:0]    wr_ptr_b;
  logic [mmc_pkg::QCNT_W-1:0]    push_n;
  logic                          do_pop;

  // Status toward both sides
  assign room_o     = count_q <= mmc_pkg::QCNT_W'(mmc_pkg::QDEPTH - 2);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign do_pop     = pop_i && rd_valid_o;

  // Pointer and count arithmetic
  assign wr_ptr_b = wr_ptr_q + mmc_pkg::QPTR_W'(1);
  assign push_n   = mmc_pkg::QCNT_W'(push_i.push_a) + mmc_pkg::QCNT_W'(push_i.push_b);

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n[mmc_pkg::QPTR_W-1:0];
    rd_ptr_d = rd_ptr_q + mmc_pkg::QPTR_W'(do_pop);
    count_d  = count_q + push_n - mmc_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      slot_q[wr_ptr_q] <= rec_a_i;
    end
    if (push_i.push_b) begin
      slot_q[wr_ptr_b] <= rec_b_i;
    end
  end

endmodule

FILE: src/mmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_back: virtual address assignment and output register
// Holds the configuration registers, gives MMIO entries consecutive virtual
// addresses and runtime entries a relocated one, and drives the output word.
// ----------------------------------------------------------------------------
module mmc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mmc_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                         q_valid_i,
  input  mmc_pkg::entry_t              q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mmc_pkg::TYPE_W-1:0]   out_type_o,
  output logic [mmc_pkg::ADDR_W-1:0]   out_phys_start_o,
  output logic [mmc_pkg::ADDR_W-1:0]   out_virt_start_o,
  output logic [mmc_pkg::PAGES_W-1:0]  out_page_count_o,
  output logic [mmc_pkg::ATTR_W-1:0]   out_attr_o,
  output logic                         out_last_o,
  output logic                         out_error_o
);

  logic [mmc_pkg::ADDR_W-1:0] rt_offset_q;
  logic [mmc_pkg::ADDR_W-1:0] mmio_start_q;
  logic [mmc_pkg::ADDR_W-1:0] mmio_next_q, mmio_next_d;
  logic                       map_start_q, map_start_d;
  logic                       out_valid_q, out_valid_d;
  mmc_pkg::entry_t            out_q, out_d;
  logic [mmc_pkg::ADDR_W-1:0] mmio_cur;
  logic [mmc_pkg::ADDR_W-1:0] mmio_adv;
  logic [mmc_pkg::ADDR_W-1:0] rt_virt;
  logic                       is_mmio;
  logic                       pop;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_offset_q  <= '0;
      mmio_start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mmc_pkg::cfg_reg_e'(cfg_idx_i))
        mmc_pkg::REG_RT_OFFSET:  rt_offset_q  <= cfg_wdata_i;
        mmc_pkg::REG_MMIO_START: mmio_start_q <= cfg_wdata_i;
        default:                 rt_offset_q  <= rt_offset_q;
      endcase
    end
  end

  // Take a record whenever the output register is free or being drained.
  assign pop     = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  // Address assignment; the MMIO counter restarts at the MMIO start register for each map.
  assign is_mmio  = mmc_pkg::type_is_mmio(q_data_i.mem_type);
  assign mmio_cur = map_start_q ? mmio_start_q : mmio_next_q;
  assign mmio_adv = mmio_cur + {q_data_i.pages, {mmc_pkg::PAGE_SHIFT{1'b0}}};
  assign rt_virt  = q_data_i.phys + rt_offset_q;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mmio_next_d = mmio_next_q;
    map_start_d = map_start_q;
    if (pop) begin
      out_d       = q_data_i;
      out_valid_d = 1'b1;
      mmio_next_d = is_mmio ? mmio_adv : mmio_cur;
      map_start_d = q_data_i.last;
      priority if (is_mmio) begin
        out_d.virt = mmio_cur;
      end else if (q_data_i.attr[mmc_pkg::ATTR_RUNTIME_BIT]) begin
        out_d.virt = rt_virt;
      end else begin
        out_d.virt = q_data_i.virt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      map_start_q <= 1'b1;
      mmio_next_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      map_start_q <= map_start_d;
      mmio_next_q <= mmio_next_d;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_type_o       = out_q.mem_type;
  assign out_phys_start_o = out_q.phys;
  assign out_virt_start_o = out_q.virt;
  assign out_page_count_o = out_q.pages;
  assign out_attr_o       = out_q.attr;
  assign out_last_o       = out_q.last;
  assign out_error_o      = out_q.error;

endmodule

FILE: src/mmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_checker: port-level checks of the memory map coalescer
// Watches the output channel for error words, reclaimed types and stalls.
// ----------------------------------------------------------------------------
module mmc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mmc_pkg::TYPE_W-1:0]   out_type_i,
  input logic [mmc_pkg::ADDR_W-1:0]   out_phys_start_i,
  input logic [mmc_pkg::ADDR_W-1:0]   out_virt_start_i,
  input logic [mmc_pkg::PAGES_W-1:0]  out_page_count_i,
  input logic [mmc_pkg::ATTR_W-1:0]   out_attr_i,
  input logic                         out_last_i,
  input logic                         out_error_i
);

  // An error word always closes its map.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_last_i)
    else $error("error word without last flag");

  // An error word carries nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> (out_type_i == '0) && (out_phys_start_i == '0) &&
      (out_virt_start_i == '0) && (out_page_count_i == '0) && (out_attr_i == '0))
    else $error("error word with nonzero fields");

  // Only kept or conventional types leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_type_i == mmc_pkg::TYPE_RESERVED) ||
      (out_type_i == mmc_pkg::TYPE_LOADER_CODE) ||
      (out_type_i == mmc_pkg::TYPE_LOADER_DATA) ||
      (out_type_i == mmc_pkg::TYPE_RT_CODE) || (out_type_i == mmc_pkg::TYPE_RT_DATA) ||
      (out_type_i == mmc_pkg::TYPE_CONVENTIONAL) ||
      (out_type_i == mmc_pkg::TYPE_UNUSABLE) || (out_type_i == mmc_pkg::TYPE_MMIO) ||
      (out_type_i == mmc_pkg::TYPE_MMIO_PORT))
    else $error("unreclaimed memory type on output");

  // A stalled output word stays valid and holds its virtual address, page count and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_virt_start_i) &&
      $stable(out_page_count_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

endmodule

bind memory_map_coalescer mmc_checker u_mmc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_type_i       (out_type_o),
  .out_phys_start_i (out_phys_start_o),
  .out_virt_start_i (out_virt_start_o),
  .out_page_count_i (out_page_count_o),
  .out_attr_i       (out_attr_o),
  .out_last_i       (out_last_o),
  .out_error_i      (out_error_o)
);
